// ===== src/msfd_pkg.sv =====
`timescale 1ns / 1ps
package msfd_pkg;

   // default sizing
   localparam int DEF_BUFFER_BYTES = 512;
   localparam int DEF_MAX_PAYLOAD  = 256;

   // frame layout
   localparam int HDR_BYTES    = 14;
   localparam int CRC_BYTES    = 2;
   localparam int NUM_COUNTERS = 10;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // request modes
   localparam logic [2:0] MODE_BYTE     = 3'd0;
   localparam logic [2:0] MODE_EXPIRY   = 3'd1;
   localparam logic [2:0] MODE_OVERFLOW = 3'd2;
   localparam logic [2:0] MODE_RESET    = 3'd3;
   localparam logic [2:0] MODE_READ     = 3'd4;

   // diagnostic counter indexes
   localparam logic [3:0] C_ACCEPT   = 4'd0;
   localparam logic [3:0] C_FRAMING  = 4'd1;
   localparam logic [3:0] C_LENGTH   = 4'd2;
   localparam logic [3:0] C_CRC      = 4'd3;
   localparam logic [3:0] C_VERSION  = 4'd4;
   localparam logic [3:0] C_FLAGS    = 4'd5;
   localparam logic [3:0] C_RESERVED = 4'd6;
   localparam logic [3:0] C_SEQUENCE = 4'd7;
   localparam logic [3:0] C_TIMEOUT  = 4'd8;
   localparam logic [3:0] C_OVERFLOW = 4'd9;

   // csr map
   localparam int CSR_AW = 5;
   localparam logic [2:0] REG_MAGIC    = 3'd0;
   localparam logic [2:0] REG_VERSION  = 3'd1;
   localparam logic [2:0] REG_TIMEOUT  = 3'd2;
   localparam logic [2:0] REG_FLAG_REQ = 3'd3;
   localparam logic [2:0] REG_FLAG_RSP = 3'd4;
   localparam logic [2:0] REG_FLAG_ERR = 3'd5;

   localparam logic [31:0] RST_MAGIC    = 32'd0;
   localparam logic [7:0]  RST_VERSION  = 8'd1;
   localparam logic [31:0] RST_TIMEOUT  = 32'd100;
   localparam logic [7:0]  RST_FLAG_REQ = 8'd0;
   localparam logic [7:0]  RST_FLAG_RSP = 8'd1;
   localparam logic [7:0]  RST_FLAG_ERR = 8'd2;

   typedef struct packed {
      logic [31:0] magic;
      logic [7:0]  version;
      logic [31:0] timeout;
      logic [7:0]  flag_req;
      logic [7:0]  flag_rsp;
      logic [7:0]  flag_err;
   } msfd_cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD_CNT,
      OP_SCAN_INIT,
      OP_SEEK_STEP,
      OP_DROP_POS,
      OP_DROP_TAIL,
      OP_HDR_INIT,
      OP_HDR_STEP,
      OP_PAY_STEP,
      OP_CRCL_STEP,
      OP_CRCH_STEP,
      OP_DROP_ONE,
      OP_DROP_FRAME,
      OP_EMIT_INIT,
      OP_EMIT_STEP,
      OP_EMIT_LOAD
   } msfd_op_type;

   typedef struct packed {
      msfd_op_type op;
      logic [3:0]  cause;
   } msfd_cmd_type;

   typedef struct packed {
      logic fill_lt4;
      logic fill_lt_hdr;
      logic magic_hit;
      logic seek_end;
      logic hdr_last;
      logic len_bad;
      logic fill_lt_frame;
      logic len_zero;
      logic pay_last;
      logic crc_bad;
      logic version_bad;
      logic flag_bad;
      logic rsvd_bad;
      logic seq_zero;
      logic byte_last;
      logic word_last;
      logic out_free;
   } msfd_status_type;

endpackage

// ===== src/msfd_ram.sv =====
`timescale 1ns / 1ps
module msfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/msfd_ctrl.sv =====
`timescale 1ns / 1ps
module msfd_ctrl import msfd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_accept,
   input  logic [2:0]      req_mode,
   output logic            req_ready,
   input  msfd_status_type status,
   output msfd_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_CNT, S_SCAN, S_SEEK, S_HDR_CHK, S_HREAD, S_LEN_CHK, S_PREAD,
      S_CRC_LO, S_CRC_HI, S_CHECK, S_EREAD, S_EMIT, S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;   // 0: read address settling, 1: data valid

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      cmd.op    = OP_NONE;
      cmd.cause = C_ACCEPT;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_mode == MODE_BYTE) begin
                  state_in = S_SCAN;
               end else if (req_mode == MODE_READ) begin
                  state_in = S_CNT;
               end
            end
         end
         S_CNT: begin
            if (status.out_free) begin
               cmd.op   = OP_LOAD_CNT;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (status.fill_lt4) begin
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_SCAN_INIT;
               state_in = S_SEEK;
            end
         end
         S_SEEK: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (status.magic_hit) begin
                  cmd.op   = OP_DROP_POS;
                  state_in = S_HDR_CHK;
               end else if (status.seek_end) begin
                  cmd.op   = OP_DROP_TAIL;
                  state_in = S_IDLE;
               end else begin
                  cmd.op = OP_SEEK_STEP;
               end
            end
         end
         S_HDR_CHK: begin
            if (status.fill_lt_hdr) begin
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_HDR_INIT;
               state_in = S_HREAD;
            end
         end
         S_HREAD: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               cmd.op = OP_HDR_STEP;
               if (status.hdr_last) begin
                  state_in = S_LEN_CHK;
               end
            end
         end
         S_LEN_CHK: begin
            if (status.len_bad) begin
               cmd.op    = OP_DROP_ONE;
               cmd.cause = C_LENGTH;
               state_in  = S_SCAN;
            end else if (status.fill_lt_frame) begin
               state_in = S_IDLE;
            end else if (status.len_zero) begin
               state_in = S_CRC_LO;
            end else begin
               state_in = S_PREAD;
            end
         end
         S_PREAD: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               cmd.op = OP_PAY_STEP;
               if (status.pay_last) begin
                  state_in = S_CRC_LO;
               end
            end
         end
         S_CRC_LO: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               cmd.op   = OP_CRCL_STEP;
               state_in = S_CRC_HI;
            end
         end
         S_CRC_HI: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               cmd.op   = OP_CRCH_STEP;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_SCAN;
            if (status.crc_bad) begin
               cmd.op    = OP_DROP_ONE;
               cmd.cause = C_CRC;
            end else if (status.version_bad) begin
               cmd.op    = OP_DROP_FRAME;
               cmd.cause = C_VERSION;
            end else if (status.flag_bad) begin
               cmd.op    = OP_DROP_FRAME;
               cmd.cause = C_FLAGS;
            end else if (status.rsvd_bad) begin
               cmd.op    = OP_DROP_FRAME;
               cmd.cause = C_RESERVED;
            end else if (status.seq_zero) begin
               cmd.op    = OP_DROP_FRAME;
               cmd.cause = C_SEQUENCE;
            end else begin
               cmd.op   = OP_EMIT_INIT;
               state_in = S_EREAD;
            end
         end
         S_EREAD: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               cmd.op = OP_EMIT_STEP;
               if (status.byte_last) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT_LOAD;
               state_in = status.word_last ? S_FIN : S_EREAD;
            end
         end
         S_FIN: begin
            cmd.op    = OP_DROP_FRAME;
            cmd.cause = C_ACCEPT;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT_LOAD || cmd.op == OP_LOAD_CNT) |-> status.out_free)
      else $error("result loaded while output register busy");

   a_phase_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !phase_ff)
      else $error("read phase left set in idle");
`endif

endmodule

// ===== src/msfd_dpath.sv =====
`timescale 1ns / 1ps
module msfd_dpath import msfd_pkg::*; #(
   parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
   parameter int MAX_PAYLOAD  = DEF_MAX_PAYLOAD
) (
   input  logic            clock,
   input  logic            reset,
   input  msfd_cfg_type    cfg,
   input  logic            req_accept,
   input  logic [2:0]      req_mode,
   input  logic [7:0]      req_byte,
   input  logic [31:0]     req_now,
   input  logic [3:0]      req_cidx,
   input  msfd_cmd_type    cmd,
   output msfd_status_type status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic            rsp_frame_valid,
   output logic [7:0]      rsp_frame_flag,
   output logic [7:0]      rsp_frame_type,
   output logic [31:0]     rsp_frame_sequence,
   output logic [8:0]      rsp_payload_length,
   output logic [4:0]      rsp_word_index,
   output logic [63:0]     rsp_payload_word,
   output logic            rsp_last,
   output logic [31:0]     rsp_counter_value
);

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int FW = $clog2(BUFFER_BYTES + 1);
   localparam int IW = $clog2(BUFFER_BYTES + MAX_PAYLOAD + 32);
   localparam int SW = IW + 1;
   localparam int OW = $clog2(MAX_PAYLOAD + 16);

   function automatic logic [AW-1:0] wrap_addr(input logic [SW-1:0] s);
      logic [SW-1:0] t;
      t = (s >= SW'(BUFFER_BYTES)) ? s - SW'(BUFFER_BYTES) : s;
      return t[AW-1:0];
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      end
      return r;
   endfunction

   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [31:0]   last_time_ff, last_time_in;
   logic          have_ff, have_in;
   logic [31:0]   cnt_ff [NUM_COUNTERS];
   logic [NUM_COUNTERS-1:0] bump;
   logic [IW-1:0] idx_ff, idx_in;
   logic [31:0]   win_ff, win_in;
   logic [15:0]   crc_ff, crc_in;
   logic [79:0]   hdr_ff, hdr_in;
   logic [15:0]   crc_rx_ff, crc_rx_in;
   logic [OW-1:0] off_ff, off_in;
   logic [4:0]    w_ff, w_in;
   logic [63:0]   word_ff, word_in;
   logic [3:0]    cidx_ff, cidx_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          o_fv_ff, o_fv_in, o_last_ff, o_last_in;
   logic [7:0]    o_flag_ff, o_flag_in, o_type_ff, o_type_in;
   logic [31:0]   o_seq_ff, o_seq_in, o_cnt_ff, o_cnt_in;
   logic [8:0]    o_len_ff, o_len_in;
   logic [4:0]    o_widx_ff, o_widx_in;
   logic [63:0]   o_word_ff, o_word_in;

   // ram
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    rdata;

   // header fields
   logic [7:0]  h_version, h_flag, h_type, h_rsvd;
   logic [31:0] h_seq;
   logic [15:0] h_len;
   logic [16:0] len17;
   logic [15:0] lm1;
   logic [4:0]  words_m1;

   logic          gap;
   logic [FW-1:0] f0, f1, drop_n;
   logic          do_drop;
   logic [31:0]   win_next;
   logic [1:0]    keep;

   assign h_version = hdr_ff[7:0];
   assign h_flag    = hdr_ff[15:8];
   assign h_type    = hdr_ff[23:16];
   assign h_rsvd    = hdr_ff[31:24];
   assign h_seq     = hdr_ff[63:32];
   assign h_len     = hdr_ff[79:64];
   assign len17     = {1'b0, h_len};
   assign lm1       = h_len - 16'd1;

   always_comb begin
      if (h_len == 16'd0) begin
         words_m1 = 5'd0;
      end else if (lm1[15:3] > 13'd31) begin
         words_m1 = 5'd31;
      end else begin
         words_m1 = lm1[7:3];
      end
   end

   assign gap = have_ff && (fill_ff != '0) && ((req_now - last_time_ff) >= cfg.timeout);
   assign f0  = gap ? '0 : fill_ff;
   assign f1  = (f0 >= FW'(BUFFER_BYTES)) ? '0 : f0;

   assign win_next = {rdata, win_ff[31:8]};

   always_comb begin
      if (win_next[31:8] == cfg.magic[23:0]) begin
         keep = 2'd3;
      end else if (win_next[31:16] == cfg.magic[15:0]) begin
         keep = 2'd2;
      end else if (win_next[31:24] == cfg.magic[7:0]) begin
         keep = 2'd1;
      end else begin
         keep = 2'd0;
      end
   end

   msfd_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_byte),
      .rd_addr (wrap_addr(SW'(head_ff) + SW'(idx_ff))),
      .rd_data (rdata)
   );

   assign wr_en   = req_accept && (req_mode == MODE_BYTE);
   assign wr_addr = wrap_addr(SW'(head_ff) + SW'(f1));

   // status
   always_comb begin
      status.fill_lt4      = fill_ff < FW'(4);
      status.fill_lt_hdr   = fill_ff < FW'(HDR_BYTES);
      status.magic_hit     = (idx_ff >= IW'(3)) && (win_next == cfg.magic);
      status.seek_end      = (SW'(idx_ff) + SW'(1)) == SW'(fill_ff);
      status.hdr_last      = idx_ff == IW'(HDR_BYTES - 1);
      status.len_bad       = len17 > 17'(MAX_PAYLOAD);
      status.fill_lt_frame = 17'(fill_ff) < (len17 + 17'(HDR_BYTES + CRC_BYTES));
      status.len_zero      = h_len == 16'd0;
      status.pay_last      = 17'(idx_ff) == (len17 + 17'(HDR_BYTES - 1));
      status.crc_bad       = crc_rx_ff != crc_ff;
      status.version_bad   = h_version != cfg.version;
      status.flag_bad      = (h_flag != cfg.flag_req) && (h_flag != cfg.flag_rsp) &&
                             (h_flag != cfg.flag_err);
      status.rsvd_bad      = h_rsvd != 8'd0;
      status.seq_zero      = h_seq == 32'd0;
      status.byte_last     = off_ff[2:0] == 3'd7;
      status.word_last     = w_ff == words_m1;
      status.out_free      = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      head_in      = head_ff;
      fill_in      = fill_ff;
      last_time_in = last_time_ff;
      have_in      = have_ff;
      bump         = '0;
      idx_in       = idx_ff;
      win_in       = win_ff;
      crc_in       = crc_ff;
      hdr_in       = hdr_ff;
      crc_rx_in    = crc_rx_ff;
      off_in       = off_ff;
      w_in         = w_ff;
      word_in      = word_ff;
      cidx_in      = cidx_ff;
      drop_n       = '0;
      do_drop      = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_fv_in      = o_fv_ff;
      o_last_in    = o_last_ff;
      o_flag_in    = o_flag_ff;
      o_type_in    = o_type_ff;
      o_seq_in     = o_seq_ff;
      o_cnt_in     = o_cnt_ff;
      o_len_in     = o_len_ff;
      o_widx_in    = o_widx_ff;
      o_word_in    = o_word_ff;

      if (req_accept) begin
         unique case (req_mode)
            MODE_BYTE: begin
               fill_in      = f1 + FW'(1);
               last_time_in = req_now;
               have_in      = 1'b1;
               bump[C_TIMEOUT]  = gap;
               bump[C_OVERFLOW] = f0 >= FW'(BUFFER_BYTES);
            end
            MODE_EXPIRY: begin
               fill_in         = f0;
               bump[C_TIMEOUT] = gap;
            end
            MODE_OVERFLOW: begin
               fill_in          = '0;
               have_in          = 1'b0;
               bump[C_OVERFLOW] = 1'b1;
            end
            MODE_RESET: begin
               fill_in      = '0;
               last_time_in = '0;
               have_in      = 1'b0;
            end
            MODE_READ: begin
               cidx_in = req_cidx;
            end
            default: ;
         endcase
      end

      case (cmd.op)
         OP_LOAD_CNT: begin
            rsp_valid_in = 1'b1;
            o_fv_in      = 1'b0;
            o_last_in    = 1'b1;
            o_flag_in    = '0;
            o_type_in    = '0;
            o_seq_in     = '0;
            o_len_in     = '0;
            o_widx_in    = '0;
            o_word_in    = '0;
            o_cnt_in     = (cidx_ff < 4'(NUM_COUNTERS)) ? cnt_ff[cidx_ff] : 32'd0;
         end
         OP_SCAN_INIT: begin
            idx_in = '0;
            win_in = '0;
         end
         OP_SEEK_STEP: begin
            win_in = win_next;
            idx_in = idx_ff + IW'(1);
         end
         OP_DROP_POS: begin
            do_drop = 1'b1;
            drop_n  = FW'(idx_ff - IW'(3));
            bump[C_FRAMING] = idx_ff != IW'(3);
         end
         OP_DROP_TAIL: begin
            do_drop = 1'b1;
            drop_n  = fill_ff - FW'(keep);
            bump[C_FRAMING] = fill_ff != FW'(keep);
         end
         OP_HDR_INIT: begin
            idx_in = IW'(4);
            crc_in = CRC_INIT;
         end
         OP_HDR_STEP: begin
            hdr_in = {rdata, hdr_ff[79:8]};
            crc_in = crc_byte(crc_ff, rdata);
            idx_in = idx_ff + IW'(1);
         end
         OP_PAY_STEP: begin
            crc_in = crc_byte(crc_ff, rdata);
            idx_in = idx_ff + IW'(1);
         end
         OP_CRCL_STEP: begin
            crc_rx_in[7:0] = rdata;
            idx_in = idx_ff + IW'(1);
         end
         OP_CRCH_STEP: begin
            crc_rx_in[15:8] = rdata;
         end
         OP_DROP_ONE: begin
            do_drop = 1'b1;
            drop_n  = FW'(1);
            bump[cmd.cause] = 1'b1;
         end
         OP_DROP_FRAME: begin
            do_drop = 1'b1;
            drop_n  = FW'(len17 + 17'(HDR_BYTES + CRC_BYTES));
            bump[cmd.cause] = 1'b1;
         end
         OP_EMIT_INIT: begin
            idx_in = IW'(HDR_BYTES);
            off_in = '0;
            w_in   = '0;
         end
         OP_EMIT_STEP: begin
            word_in = {((17'(off_ff) < len17) ? rdata : 8'd0), word_ff[63:8]};
            off_in  = off_ff + OW'(1);
            idx_in  = idx_ff + IW'(1);
         end
         OP_EMIT_LOAD: begin
            rsp_valid_in = 1'b1;
            o_fv_in      = 1'b1;
            o_last_in    = w_ff == words_m1;
            o_flag_in    = h_flag;
            o_type_in    = h_type;
            o_seq_in     = h_seq;
            o_len_in     = h_len[8:0];
            o_widx_in    = w_ff;
            o_word_in    = word_ff;
            o_cnt_in     = '0;
            w_in         = w_ff + 5'd1;
         end
         default: ;
      endcase

      if (do_drop) begin
         head_in = wrap_addr(SW'(head_ff) + SW'(drop_n));
         fill_in = fill_ff - drop_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         last_time_ff <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         last_time_ff <= last_time_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            if (bump[i] && (cnt_ff[i] != '1)) begin
               cnt_ff[i] <= cnt_ff[i] + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      win_ff    <= win_in;
      crc_ff    <= crc_in;
      hdr_ff    <= hdr_in;
      crc_rx_ff <= crc_rx_in;
      off_ff    <= off_in;
      w_ff      <= w_in;
      word_ff   <= word_in;
      cidx_ff   <= cidx_in;
      o_fv_ff   <= o_fv_in;
      o_last_ff <= o_last_in;
      o_flag_ff <= o_flag_in;
      o_type_ff <= o_type_in;
      o_seq_ff  <= o_seq_in;
      o_cnt_ff  <= o_cnt_in;
      o_len_ff  <= o_len_in;
      o_widx_ff <= o_widx_in;
      o_word_ff <= o_word_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_valid    = o_fv_ff;
   assign rsp_frame_flag     = o_flag_ff;
   assign rsp_frame_type     = o_type_ff;
   assign rsp_frame_sequence = o_seq_ff;
   assign rsp_payload_length = o_len_ff;
   assign rsp_word_index     = o_widx_ff;
   assign rsp_payload_word   = o_word_ff;
   assign rsp_last           = o_last_ff;
   assign rsp_counter_value  = o_cnt_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(BUFFER_BYTES))
      else $error("fill count beyond buffer size");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      SW'(head_ff) < SW'(BUFFER_BYTES))
      else $error("head pointer out of range");

   a_accept_cnt_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> cnt_ff[C_ACCEPT] >= $past(cnt_ff[C_ACCEPT]))
      else $error("accept counter decreased");
`endif

endmodule

// ===== src/magic_sync_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
// Magic-word frame deframer with CRC-16/CCITT-FALSE.
// req_* : stream of items (mode, link byte, ms timestamp, counter index).
//   Mode 0 pushes a byte, 1 checks the inter-byte timeout, 2 flags a transport
//   overflow, 3 resets the parser, 4 reads a diagnostic counter.
// rsp_* : accepted frames as 64-bit payload words (tuser = frame valid,
//   tlast on the final word), or one counter value for mode 4.
// csr_* : APB-style register port for magic word, version, timeout and the
//   three accepted flag codes.
// Throughput: one item at a time. Modes 1-3 and 5-7 leave the controller idle. A
//   byte starts a rescan of the receive buffer by the controller, each buffered
//   byte read through a RAM with registered read: the magic search, the
//   header/payload CRC pass, and, for an accepted frame, a pass that packs eight
//   payload bytes into each output word.
// Reset clears the buffer fill, timestamps, counters and registers; no clearing
//   pass. When the receiver stalls the output register holds its word and the
//   controller waits before loading the next one; req_tready stays low.
module magic_sync_frame_deframer_unit import msfd_pkg::*; #(
   parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
   parameter int MAX_PAYLOAD  = DEF_MAX_PAYLOAD
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [2:0] mode, [10:3] data_byte, [42:11] now_ms, [46:43] counter_index
   input  logic [47:0]       req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [7:0] frame_flag, [15:8] frame_type, [47:16] frame_sequence,
   // [56:48] payload_length, [61:57] word_index, [125:62] payload_word,
   // [157:126] counter_value
   output logic [159:0]      rsp_tdata,
   // [0] frame_valid
   output logic              rsp_tuser,
   output logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   msfd_cfg_type    cfg_ff, cfg_in;
   msfd_cmd_type    cmd;
   msfd_status_type status;
   logic            req_accept;
   logic            csr_wr;
   logic [2:0]      reg_sel;

   logic [7:0]  o_flag, o_type;
   logic [31:0] o_seq, o_cnt;
   logic [8:0]  o_len;
   logic [4:0]  o_widx;
   logic [63:0] o_word;

   assign req_accept = req_tvalid && req_tready;

   // register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (reg_sel)
            REG_MAGIC:    cfg_in.magic    = csr_pwdata;
            REG_VERSION:  cfg_in.version  = csr_pwdata[7:0];
            REG_TIMEOUT:  cfg_in.timeout  = csr_pwdata;
            REG_FLAG_REQ: cfg_in.flag_req = csr_pwdata[7:0];
            REG_FLAG_RSP: cfg_in.flag_rsp = csr_pwdata[7:0];
            REG_FLAG_ERR: cfg_in.flag_err = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MAGIC:    csr_prdata = cfg_ff.magic;
         REG_VERSION:  csr_prdata = {24'd0, cfg_ff.version};
         REG_TIMEOUT:  csr_prdata = cfg_ff.timeout;
         REG_FLAG_REQ: csr_prdata = {24'd0, cfg_ff.flag_req};
         REG_FLAG_RSP: csr_prdata = {24'd0, cfg_ff.flag_rsp};
         REG_FLAG_ERR: csr_prdata = {24'd0, cfg_ff.flag_err};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic    <= RST_MAGIC;
         cfg_ff.version  <= RST_VERSION;
         cfg_ff.timeout  <= RST_TIMEOUT;
         cfg_ff.flag_req <= RST_FLAG_REQ;
         cfg_ff.flag_rsp <= RST_FLAG_RSP;
         cfg_ff.flag_err <= RST_FLAG_ERR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   msfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_mode   (req_tdata[2:0]),
      .req_ready  (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // buffer, checks, counters and output register
   msfd_dpath #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .MAX_PAYLOAD  (MAX_PAYLOAD)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_accept         (req_accept),
      .req_mode           (req_tdata[2:0]),
      .req_byte           (req_tdata[10:3]),
      .req_now            (req_tdata[42:11]),
      .req_cidx           (req_tdata[46:43]),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_frame_valid    (rsp_tuser),
      .rsp_frame_flag     (o_flag),
      .rsp_frame_type     (o_type),
      .rsp_frame_sequence (o_seq),
      .rsp_payload_length (o_len),
      .rsp_word_index     (o_widx),
      .rsp_payload_word   (o_word),
      .rsp_last           (rsp_tlast),
      .rsp_counter_value  (o_cnt)
   );

   assign rsp_tdata = {2'b00, o_cnt, o_word, o_widx, o_len, o_seq, o_type, o_flag};

endmodule

// ===== bench/tb_magic_sync_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
module tb_magic_sync_frame_deframer_unit;
   import msfd_pkg::*;

   localparam int BUF_BYTES  = DEF_BUFFER_BYTES;
   localparam int MAX_PAY    = DEF_MAX_PAYLOAD;
   localparam int MAX_WORDS  = 32;
   localparam int SETTLE     = 4000;   // worst buffer rescan plus emit, with margin
   localparam int IDLE_LIMIT = 40000;  // cycles without any handshake

   // one request item as it goes into the queue
   typedef struct packed {
      bit         hold;   // wait for all results before presenting
      bit [2:0]   mode;
      bit [7:0]   byt;
      bit [31:0]  now;
      bit [3:0]   idx;
   } req_item_t;

   // one expected result item
   typedef struct packed {
      bit         fv;
      bit [7:0]   flag;
      bit [7:0]   typ;
      bit [31:0]  seq;
      bit [8:0]   len;
      bit [4:0]   widx;
      bit [63:0]  word;
      bit         last;
      bit [31:0]  cval;
   } frame_word_t;

   typedef bit [7:0] byte_q_t[$];

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [47:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [159:0]  rsp_tdata;
   logic          rsp_tuser;
   logic          rsp_tlast;
   logic          csr_psel = 0;
   logic          csr_penable = 0;
   logic          csr_pwrite = 0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   magic_sync_frame_deframer_unit uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // ---------------------------------------------------------------
   // deframer shadow state
   // ---------------------------------------------------------------
   msfd_cfg_type  cfg;
   bit [7:0]      rx_buf [BUF_BYTES];
   int            rx_fill;
   bit [31:0]     last_ms;
   bit            have_ms;
   bit [31:0]     diag [NUM_COUNTERS];

   frame_word_t   word_q [$];     // results still owed by the block
   req_item_t     pend_q [$];     // items not yet presented
   req_item_t     cur_req;

   int            errors;
   int            n_sent, n_words, n_frames;
   int            send_wait, recv_wait, gap_scale;
   int            idle_cnt;
   bit [31:0]     t_ms;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   function automatic void bump(input int i);
      if (diag[i] != 32'hFFFF_FFFF) diag[i]++;
   endfunction

   function automatic bit [15:0] crc16(input byte_q_t q);
      bit [15:0] c;
      c = CRC_INIT;
      foreach (q[i]) begin
         c ^= {q[i], 8'h00};
         for (int j = 0; j < 8; j++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic void drop(input int n);
      if (n > rx_fill) n = rx_fill;
      for (int i = 0; i < rx_fill - n; i++) rx_buf[i] = rx_buf[i + n];
      rx_fill -= n;
   endfunction

   function automatic void gap_check(input bit [31:0] now);
      if (have_ms && rx_fill != 0 && (now - last_ms) >= cfg.timeout) begin
         rx_fill = 0;
         bump(C_TIMEOUT);
      end
   endfunction

   function automatic int find_magic();
      bit hit;
      for (int p = 0; p + 4 <= rx_fill; p++) begin
         hit = 1;
         for (int k = 0; k < 4; k++)
            if (rx_buf[p + k] != cfg.magic[8*k +: 8]) hit = 0;
         if (hit) return p;
      end
      return rx_fill;
   endfunction

   // longest buffer tail that is a magic prefix
   function automatic int magic_tail();
      bit hit;
      for (int n = (rx_fill < 3 ? rx_fill : 3); n > 0; n--) begin
         hit = 1;
         for (int k = 0; k < n; k++)
            if (rx_buf[rx_fill - n + k] != cfg.magic[8*k +: 8]) hit = 0;
         if (hit) return n;
      end
      return 0;
   endfunction

   function automatic void emit_words(input int len);
      int words;
      frame_word_t w;
      words = (len + 7) / 8;
      if (words == 0) words = 1;
      if (words > MAX_WORDS) words = MAX_WORDS;
      for (int i = 0; i < words; i++) begin
         w = '0;
         w.fv   = 1;
         w.flag = rx_buf[5];
         w.typ  = rx_buf[6];
         w.seq  = {rx_buf[11], rx_buf[10], rx_buf[9], rx_buf[8]};
         w.len  = len;
         w.widx = i;
         for (int k = 0; k < 8; k++)
            if (i*8 + k < len) w.word[8*k +: 8] = rx_buf[HDR_BYTES + i*8 + k];
         w.last = (i == words - 1);
         word_q.push_back(w);
      end
      n_frames++;
   endfunction

   function automatic void link_byte(input bit [7:0] b, input bit [31:0] now);
      int pos, keep, len, flen;
      bit [15:0] want;
      byte_q_t span;
      gap_check(now);
      have_ms = 1;
      last_ms = now;
      if (rx_fill >= BUF_BYTES) begin
         rx_fill = 0;
         bump(C_OVERFLOW);
      end
      rx_buf[rx_fill] = b;
      rx_fill++;
      forever begin
         if (rx_fill < 4) return;
         pos = find_magic();
         if (pos == rx_fill) begin
            keep = magic_tail();
            if (rx_fill > keep) begin
               drop(rx_fill - keep);
               bump(C_FRAMING);
            end
            return;
         end
         if (pos != 0) begin
            drop(pos);
            bump(C_FRAMING);
         end
         if (rx_fill < HDR_BYTES) return;
         len = {rx_buf[13], rx_buf[12]};
         if (len > MAX_PAY) begin
            // bad length: slip one byte and rescan
            drop(1);
            bump(C_LENGTH);
            continue;
         end
         flen = HDR_BYTES + len + CRC_BYTES;
         if (rx_fill < flen) return;
         span.delete();
         for (int i = 4; i < HDR_BYTES + len; i++) span.push_back(rx_buf[i]);
         want = {rx_buf[HDR_BYTES + len + 1], rx_buf[HDR_BYTES + len]};
         if (want != crc16(span)) begin
            drop(1);
            bump(C_CRC);
            continue;
         end
         // header faults below drop the whole frame
         if (rx_buf[4] != cfg.version) begin
            drop(flen);
            bump(C_VERSION);
            continue;
         end
         if (rx_buf[5] != cfg.flag_req && rx_buf[5] != cfg.flag_rsp &&
             rx_buf[5] != cfg.flag_err) begin
            drop(flen);
            bump(C_FLAGS);
            continue;
         end
         if (rx_buf[7] != 0) begin
            drop(flen);
            bump(C_RESERVED);
            continue;
         end
         if ({rx_buf[11], rx_buf[10], rx_buf[9], rx_buf[8]} == 0) begin
            drop(flen);
            bump(C_SEQUENCE);
            continue;
         end
         emit_words(len);
         drop(flen);
         bump(C_ACCEPT);
         return;
      end
   endfunction

   function automatic void deframe_step(input req_item_t r);
      frame_word_t w;
      case (r.mode)
         MODE_BYTE:   link_byte(r.byt, r.now);
         MODE_EXPIRY: gap_check(r.now);
         MODE_OVERFLOW: begin
            rx_fill = 0;
            have_ms = 0;
            bump(C_OVERFLOW);
         end
         MODE_RESET: begin
            rx_fill = 0;
            last_ms = 0;
            have_ms = 0;
         end
         MODE_READ: begin
            w = '0;
            w.last = 1;
            w.cval = (r.idx < NUM_COUNTERS) ? diag[r.idx] : 32'd0;
            word_q.push_back(w);
         end
         default: ;   // unused modes are ignored
      endcase
   endfunction

   // ---------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      bit nxt_valid;
      if (reset) begin
         req_tvalid <= 0;
         send_wait = 0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            deframe_step(cur_req);
            n_sent++;
            nxt_valid = 0;
            send_wait = $urandom_range(0, 10) * gap_scale;
         end
         if (!nxt_valid) begin
            if (send_wait > 0)
               send_wait--;
            else if (pend_q.size() > 0 && !(pend_q[0].hold && word_q.size() > 0)) begin
               cur_req = pend_q.pop_front();
               req_tdata <= {1'b0, cur_req.idx, cur_req.now, cur_req.byt, cur_req.mode};
               nxt_valid = 1;
            end
         end
         req_tvalid <= nxt_valid;
      end
   end

   // ---------------------------------------------------------------
   // result monitor: field-by-field compare against the oldest entry
   // ---------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      frame_word_t w;
      if (reset) begin
         rsp_tready <= 0;
         recv_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (word_q.size() == 0)
               report_mismatch("unexpected item", rsp_tdata[63:0], 0);
            else begin
               w = word_q.pop_front();
               n_words++;
               if (rsp_tuser !== w.fv) report_mismatch("frame_valid", rsp_tuser, w.fv);
               if (rsp_tdata[7:0] !== w.flag)
                  report_mismatch("frame_flag", rsp_tdata[7:0], w.flag);
               if (rsp_tdata[15:8] !== w.typ)
                  report_mismatch("frame_type", rsp_tdata[15:8], w.typ);
               if (rsp_tdata[47:16] !== w.seq)
                  report_mismatch("frame_sequence", rsp_tdata[47:16], w.seq);
               if (rsp_tdata[56:48] !== w.len)
                  report_mismatch("payload_length", rsp_tdata[56:48], w.len);
               if (rsp_tdata[61:57] !== w.widx)
                  report_mismatch("word_index", rsp_tdata[61:57], w.widx);
               if (rsp_tdata[125:62] !== w.word)
                  report_mismatch("payload_word", rsp_tdata[125:62], w.word);
               if (rsp_tlast !== w.last) report_mismatch("last", rsp_tlast, w.last);
               if (rsp_tdata[157:126] !== w.cval)
                  report_mismatch("counter_value", rsp_tdata[157:126], w.cval);
            end
            recv_wait = $urandom_range(0, 10) * gap_scale;
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 0;
         end else
            rsp_tready <= 1;
      end
   end

   // watchdog: ends a hung run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cnt = 0;
      else begin
         idle_cnt++;
         if (idle_cnt == IDLE_LIMIT) begin
            $display("timeout: %0d items owed", word_q.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   task automatic csr_write(input logic [2:0] r, input logic [31:0] v);
      @(posedge clock);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      case (r)
         REG_MAGIC:    cfg.magic    = v;
         REG_VERSION:  cfg.version  = v[7:0];
         REG_TIMEOUT:  cfg.timeout  = v;
         REG_FLAG_REQ: cfg.flag_req = v[7:0];
         REG_FLAG_RSP: cfg.flag_rsp = v[7:0];
         REG_FLAG_ERR: cfg.flag_err = v[7:0];
         default: ;
      endcase
   endtask

   task automatic push_item(input bit [2:0] mode, input bit [7:0] b, input bit [31:0] now,
                            input bit [3:0] idx, input bit hold);
      req_item_t r;
      r.hold = hold;
      r.mode = mode;
      r.byt  = b;
      r.now  = now;
      r.idx  = idx;
      pend_q.push_back(r);
   endtask

   // time step that stays inside the timeout window
   task automatic step_ms();
      if (cfg.timeout > 1)
         t_ms += $urandom_range(0, cfg.timeout > 21 ? 20 : cfg.timeout - 1);
   endtask

   task automatic push_bytes(input byte_q_t f, input int cut_at, input bit hold);
      foreach (f[i]) begin
         if (i == cut_at) t_ms += cfg.timeout + $urandom_range(0, 3);
         else step_ms();
         push_item(MODE_BYTE, f[i], t_ms, 4'($urandom), (i == 0) && hold);
      end
   endtask

   // builds a frame; crc_bad corrupts one checksum byte, cut_at opens a timeout gap
   task automatic push_frame(input bit [7:0] ver, input bit [7:0] flg, input bit [7:0] typ,
                             input bit [7:0] rsv, input bit [31:0] seq,
                             input bit [15:0] len, input bit crc_bad, input int cut_at);
      byte_q_t f, body;
      bit [15:0] c;
      for (int k = 0; k < 4; k++) f.push_back(cfg.magic[8*k +: 8]);
      f.push_back(ver);
      f.push_back(flg);
      f.push_back(typ);
      f.push_back(rsv);
      for (int k = 0; k < 4; k++) f.push_back(seq[8*k +: 8]);
      f.push_back(len[7:0]);
      f.push_back(len[15:8]);
      if (len <= MAX_PAY)
         for (int k = 0; k < len; k++) f.push_back(8'($urandom));
      for (int k = 4; k < f.size(); k++) body.push_back(f[k]);
      c = crc16(body);
      f.push_back(c[7:0]);
      f.push_back(c[15:8]);
      if (crc_bad) f[f.size() - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
      push_bytes(f, cut_at, $urandom_range(0, 9) == 0);
   endtask

   function automatic bit [7:0] good_flag();
      case ($urandom_range(0, 2))
         0: return cfg.flag_req;
         1: return cfg.flag_rsp;
         default: return cfg.flag_err;
      endcase
   endfunction

   function automatic bit [31:0] good_seq();
      bit [31:0] s;
      s = $urandom;
      return (s == 0) ? 32'd1 : s;
   endfunction

   task automatic read_counters();
      for (int i = 0; i < 16; i++)
         push_item(MODE_READ, 8'($urandom), $urandom, i[3:0], 0);
   endtask

   task automatic drain();
      while (pend_q.size() > 0 || req_tvalid || word_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // mostly well-formed frames, the rest faults, noise and control items
   task automatic random_traffic(input int n_items);
      int goal, pick, kind;
      bit [7:0] bad;
      byte_q_t noise;
      goal = pend_q.size() + n_items;
      while (pend_q.size() < goal) begin
         if ($urandom_range(0, 29) == 0) gap_scale = $urandom_range(0, 1);
         pick = $urandom_range(0, 99);
         if (pick < 55)
            push_frame(cfg.version, good_flag(), 8'($urandom), 0, good_seq(),
                       $urandom_range(0, 24), 0, -1);
         else if (pick < 72) begin
            kind = $urandom_range(0, 6);
            bad = 8'($urandom);
            while (bad == cfg.flag_req || bad == cfg.flag_rsp || bad == cfg.flag_err)
               bad++;
            case (kind)
               0: push_frame(cfg.version ^ 8'($urandom_range(1, 255)), good_flag(),
                             8'($urandom), 0, good_seq(), $urandom_range(0, 12), 0, -1);
               1: push_frame(cfg.version, bad, 8'($urandom), 0, good_seq(),
                             $urandom_range(0, 12), 0, -1);
               2: push_frame(cfg.version, good_flag(), 8'($urandom),
                             8'($urandom_range(1, 255)), good_seq(),
                             $urandom_range(0, 12), 0, -1);
               3: push_frame(cfg.version, good_flag(), 8'($urandom), 0, 0,
                             $urandom_range(0, 12), 0, -1);
               4: push_frame(cfg.version, good_flag(), 8'($urandom), 0, good_seq(),
                             $urandom_range(0, 12), 1, -1);
               5: push_frame(cfg.version, good_flag(), 8'($urandom), 0, good_seq(),
                             16'($urandom_range(MAX_PAY + 1, 65535)), 0, -1);
               default: push_frame(cfg.version, good_flag(), 8'($urandom), 0, good_seq(),
                                   $urandom_range(0, 12), 0, $urandom_range(1, 14));
            endcase
         end else if (pick < 82) begin
            noise.delete();
            repeat ($urandom_range(1, 6)) noise.push_back(8'($urandom));
            push_bytes(noise, $urandom_range(0, 1) ? 0 : -1, 0);
         end else if (pick < 88) begin
            t_ms += $urandom_range(0, 1) ? cfg.timeout : $urandom_range(0, 20);
            push_item(MODE_EXPIRY, 8'($urandom), t_ms, 4'($urandom), 0);
         end else if (pick < 91)
            push_item(MODE_OVERFLOW, 8'($urandom), $urandom, 4'($urandom), 0);
         else if (pick < 94)
            push_item(MODE_RESET, 8'($urandom), $urandom, 4'($urandom), 0);
         else if (pick < 96)
            push_item(3'($urandom_range(5, 7)), 8'($urandom), $urandom, 4'($urandom), 0);
         else
            push_item(MODE_READ, 8'($urandom), $urandom, 4'($urandom), 0);
      end
   endtask

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin
      cfg = '{magic: RST_MAGIC, version: RST_VERSION, timeout: RST_TIMEOUT,
              flag_req: RST_FLAG_REQ, flag_rsp: RST_FLAG_RSP, flag_err: RST_FLAG_ERR};
      rx_fill = 0;
      last_ms = 0;
      have_ms = 0;
      foreach (diag[i]) diag[i] = 0;
      errors = 0;
      gap_scale = 0;
      t_ms = 32'hFFFF_FFF0;   // timestamps wrap through zero early on

      repeat (9) @(posedge clock);
      reset <= 0;

      // directed, reset settings: ignored modes, out-of-range read, zero-length
      // frame, expiry on a partial frame, overflow and parser reset
      push_item(MODE_READ, 8'hFF, 32'hFFFF_FFFF, 4'hF, 0);
      push_item(3'd5, 8'h00, 32'h0, 4'h0, 0);
      push_item(3'd6, 8'hA5, 32'h1234_5678, 4'h5, 0);
      push_item(3'd7, 8'h5A, 32'h8765_4321, 4'hA, 0);
      push_frame(RST_VERSION, RST_FLAG_ERR, 8'hFF, 0, 32'hFFFF_FFFF, 0, 0, -1);
      push_frame(RST_VERSION, RST_FLAG_REQ, 8'h00, 0, 32'h1, 8, 0, -1);
      push_item(MODE_BYTE, 8'h00, t_ms, 4'h0, 0);
      push_item(MODE_EXPIRY, 8'h00, t_ms + RST_TIMEOUT, 4'h0, 1);
      push_item(MODE_OVERFLOW, 8'h00, 32'h0, 4'h0, 0);
      push_item(MODE_RESET, 8'h00, 32'h0, 4'h0, 0);
      push_item(MODE_READ, 8'h00, 32'h0, C_TIMEOUT, 0);
      drain();

      // random settings
      csr_write(REG_MAGIC, $urandom);
      csr_write(REG_VERSION, $urandom_range(0, 255));
      csr_write(REG_TIMEOUT, $urandom_range(30, 1000));
      csr_write(REG_FLAG_REQ, $urandom_range(0, 255));
      csr_write(REG_FLAG_RSP, $urandom_range(0, 255));
      csr_write(REG_FLAG_ERR, $urandom_range(0, 255));
      gap_scale = 1;
      random_traffic(130);
      read_counters();
      drain();

      // all-ones magic and version, zero timeout: no frame survives a byte gap
      csr_write(REG_MAGIC, 32'hFFFF_FFFF);
      csr_write(REG_VERSION, 8'hFF);
      csr_write(REG_TIMEOUT, 32'd0);
      csr_write(REG_FLAG_REQ, 8'hFF);
      csr_write(REG_FLAG_RSP, 8'h00);
      csr_write(REG_FLAG_ERR, 8'h80);
      random_traffic(40);
      read_counters();
      drain();

      // max timeout, zero version; one maximum-length frame and one over-length frame
      csr_write(REG_MAGIC, $urandom);
      csr_write(REG_VERSION, 8'h00);
      csr_write(REG_TIMEOUT, 32'hFFFF_FFFF);
      push_frame(8'h00, good_flag(), 8'h3C, 0, good_seq(), MAX_PAY, 0, -1);
      push_frame(8'h00, good_flag(), 8'h3C, 0, good_seq(), MAX_PAY + 1, 0, -1);
      random_traffic(130);
      read_counters();
      drain();

      $display("sent %0d items, checked %0d result items, %0d frames accepted",
               n_sent, n_words, n_frames);
      $display("covered reset, random and extreme settings with frame faults and gaps");
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
src/msfd_pkg.sv
src/msfd_ram.sv
src/msfd_ctrl.sv
src/msfd_dpath.sv
src/magic_sync_frame_deframer_unit.sv
bench/tb_magic_sync_frame_deframer_unit.sv
